FILE: src/assert_macros.svh
// Assertion macros used by the line breaker top level.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define GWW_ASSERT_PROP(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define GWW_ASSERT_NEVER(label, ck, rn, expr, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);

`else

`define GWW_ASSERT_PROP(label, ck, rn, prop, msg)
`define GWW_ASSERT_NEVER(label, ck, rn, expr, msg)

`endif

`endif

FILE: src/gww_pkg.sv
// Shared types, constants and the break-glyph classifier of the line breaker.
// No dependencies; used by gww_front, gww_back and the top level.
package gww_pkg;

    localparam int MAX_TEXT_GLYPHS = 4096;
    localparam int POS_CAPACITY    = (MAX_TEXT_GLYPHS < 4096) ? MAX_TEXT_GLYPHS : 4096;

    localparam int POS_W   = 12;
    localparam int NPOS_W  = 13;
    localparam int CODE_W  = 8;
    localparam int GLYPH_W = 8;
    localparam int LINE_W  = 12;

    localparam logic [LINE_W-1:0] LINE_WIDTH_RST = 12'd320;

    localparam int IQ_DEPTH = 4;
    localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
    localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic               eot;
        logic               brk;
        logic [GLYPH_W-1:0] width;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } item_req_t;

    typedef struct packed {
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] last;
        logic             line_valid;
        logic             text_done;
        logic             text_stopped;
        logic             text_too_long;
        logic             last_of_run;
    } result_t;

    // Codes 0-47, 58-63, 91-96 and 123-126 break; all others, @ and 127 too, do not.
    function automatic logic is_break(input logic [CODE_W-1:0] code);
        logic brk;
        brk = 1'b0;
        if (code <= 8'd47)
            brk = 1'b1;
        else if (code >= 8'd58 && code <= 8'd63)
            brk = 1'b1;
        else if (code >= 8'd91 && code <= 8'd96)
            brk = 1'b1;
        else if (code >= 8'd123 && code <= 8'd126)
            brk = 1'b1;
        return brk;
    endfunction

endpackage

FILE: src/greedy_word_wrap_line_breaker_core.sv
// Greedy word-wrap line breaker, top level; joins gww_front and gww_back.
// Depends on gww_pkg and assert_macros.svh.
// The block takes one glyph request per cycle while in_ready is high (code,
// pixel width, or an end marker) and returns the inclusive position range of
// each wrapped line for the width held in the lw_reg register (reset 320,
// written by cfg_wr_en/cfg_wr_data; the user must write it only while idle,
// and the block itself does not enforce this). Requests pass a four-entry
// classify queue, then the wrap unit, which updates its state once per glyph,
// then a four-entry result queue, whose head drives the ports and leaves when
// out_ready is high. Sustained rate is one glyph per cycle while out_ready
// stays high; a request that closes two lines, or an end marker with a
// pending line, yields two results, and results leave one per cycle, so the
// output port sets the limit when such requests cluster.
`include "assert_macros.svh"

module greedy_word_wrap_line_breaker_core
    import gww_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LINE_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CODE_W-1:0]  glyph_code,
    input  logic [GLYPH_W-1:0] glyph_width,
    input  logic               end_of_text,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [POS_W-1:0]   line_first,
    output logic [POS_W-1:0]   line_last,
    output logic               line_valid,
    output logic               text_done,
    output logic               text_stopped,
    output logic               text_too_long,
    output logic               last_of_run
);

    item_req_t head;
    logic      pop;

    gww_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .glyph_code  (glyph_code),
        .glyph_width (glyph_width),
        .end_of_text (end_of_text),
        .head        (head),
        .pop         (pop)
    );

    gww_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_first    (line_first),
        .line_last     (line_last),
        .line_valid    (line_valid),
        .text_done     (text_done),
        .text_stopped  (text_stopped),
        .text_too_long (text_too_long),
        .last_of_run   (last_of_run)
    );

    `GWW_ASSERT_PROP(a_done_is_last, clk, rst_n, out_valid && text_done |-> last_of_run && !line_valid, "final marker must close its run and carry no line")
    `GWW_ASSERT_NEVER(a_line_order, clk, rst_n, out_valid && line_valid && (line_last < line_first), "line ends before it starts")
    `GWW_ASSERT_PROP(a_pending_run, clk, rst_n, out_valid && out_ready && !last_of_run |=> out_valid, "second result of a run missing")

endmodule

FILE: src/gww_front.sv
// Front end of the line breaker: accepts glyph requests, classifies them
// and queues them for the back end. Depends on gww_pkg.
module gww_front
    import gww_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CODE_W-1:0]  glyph_code,
    input  logic [GLYPH_W-1:0] glyph_width,
    input  logic               end_of_text,
    output item_req_t          head,
    input  logic               pop
);

    item_t               q_mem [IQ_DEPTH];
    logic [IQ_PTR_W-1:0] wr_ptr_reg;
    logic [IQ_PTR_W-1:0] wr_ptr_next;
    logic [IQ_PTR_W-1:0] rd_ptr_reg;
    logic [IQ_PTR_W-1:0] rd_ptr_next;
    logic [IQ_CNT_W-1:0] count_reg;
    logic [IQ_CNT_W-1:0] count_next;
    logic                push;
    logic                do_pop;
    item_t               new_item;

    assign in_ready = (count_reg != IQ_CNT_W'(IQ_DEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != '0);

    assign new_item.eot   = end_of_text;
    assign new_item.brk   = is_break(glyph_code);
    assign new_item.width = glyph_width;

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + IQ_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + IQ_PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + IQ_CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - IQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: src/gww_back.sv
// Back end of the line breaker: runs the greedy wrap state per glyph and
// queues up to two line results per request. Depends on gww_pkg.
module gww_back
    import gww_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [LINE_W-1:0] cfg_wr_data,
    input  item_req_t         head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [POS_W-1:0]  line_first,
    output logic [POS_W-1:0]  line_last,
    output logic              line_valid,
    output logic              text_done,
    output logic              text_stopped,
    output logic              text_too_long,
    output logic              last_of_run
);

    logic [LINE_W-1:0]   lw_reg;
    logic [NPOS_W-1:0]   np_reg,   np_next;
    logic [POS_W-1:0]    ls_reg,   ls_next;
    logic [LINE_W-1:0]   used_reg, used_next;
    logic [POS_W-1:0]    lbp_reg,  lbp_next;
    logic [LINE_W-1:0]   tail_reg, tail_next;
    logic                stop_reg, stop_next;
    logic                ovf_reg,  ovf_next;

    result_t             o_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] owr_ptr_reg, owr_ptr_next;
    logic [OQ_PTR_W-1:0] ord_ptr_reg, ord_ptr_next;
    logic [OQ_CNT_W-1:0] ocount_reg,  ocount_next;
    logic [OQ_PTR_W-1:0] owr_ptr_p1;
    logic                out_pop;

    result_t             r0;
    result_t             r1;
    logic [1:0]          n_res;

    logic [POS_W-1:0]    p;
    logic [GLYPH_W-1:0]  g;
    logic                brk;
    logic [NPOS_W-1:0]   sum1;
    logic [NPOS_W-1:0]   sum2;
    logic                fit1;
    logic                fit2;
    logic                fitg;
    logic [POS_W-1:0]    ls2;
    logic [POS_W-1:0]    p_m1;
    logic [NPOS_W-1:0]   np_p1;
    logic [NPOS_W-1:0]   np_m1;
    result_t             head_res;

    function automatic result_t mk_res(input logic [POS_W-1:0] first,
                                       input logic [POS_W-1:0] last,
                                       input logic             lv,
                                       input logic             done,
                                       input logic             stopped,
                                       input logic             ovf);
        result_t r;
        r.first         = first;
        r.last          = last;
        r.line_valid    = lv;
        r.text_done     = done;
        r.text_stopped  = stopped;
        r.text_too_long = ovf;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    assign pop = head.valid && (ocount_reg <= OQ_CNT_W'(OQ_DEPTH - 2));

    assign p     = np_reg[POS_W-1:0];
    assign g     = head.item.width;
    assign brk   = head.item.brk;
    assign sum1  = {1'b0, used_reg} + NPOS_W'(g);
    assign sum2  = {1'b0, tail_reg} + NPOS_W'(g);
    assign fit1  = (sum1 <= {1'b0, lw_reg});
    assign fit2  = (sum2 <= {1'b0, lw_reg});
    assign fitg  = (LINE_W'(g) <= lw_reg);
    assign ls2   = lbp_reg + POS_W'(1);
    assign p_m1  = p - POS_W'(1);
    assign np_p1 = np_reg + NPOS_W'(1);
    assign np_m1 = np_reg - NPOS_W'(1);

    always_comb
    begin
        np_next   = np_reg;
        ls_next   = ls_reg;
        used_next = used_reg;
        lbp_next  = lbp_reg;
        tail_next = tail_reg;
        stop_next = stop_reg;
        ovf_next  = ovf_reg;
        r0        = '0;
        r1        = '0;
        n_res     = 2'd0;
        if (pop)
        begin
            if (head.item.eot)
            begin
                if (np_reg > {1'b0, ls_reg})
                begin
                    r0    = mk_res(ls_reg, np_m1[POS_W-1:0], 1'b1, 1'b0, stop_reg, ovf_reg);
                    r1    = mk_res('0, '0, 1'b0, 1'b1, stop_reg, ovf_reg);
                    n_res = 2'd2;
                end
                else
                begin
                    r0    = mk_res('0, '0, 1'b0, 1'b1, stop_reg, ovf_reg);
                    n_res = 2'd1;
                end
                np_next   = '0;
                ls_next   = '0;
                used_next = '0;
                lbp_next  = '0;
                tail_next = '0;
                stop_next = 1'b0;
                ovf_next  = 1'b0;
            end
            else if (stop_reg)
            begin
                // drop glyphs until end of text
            end
            else if (np_reg >= NPOS_W'(POS_CAPACITY))
            begin
                ovf_next = 1'b1;
            end
            else if (fit1)
            begin
                used_next = sum1[LINE_W-1:0];
                if (brk && (p != ls_reg))
                begin
                    lbp_next  = p;
                    tail_next = '0;
                end
                else
                begin
                    tail_next = sum2[LINE_W-1:0];
                end
                np_next = np_p1;
            end
            else if (p == ls_reg)
            begin
                stop_next = 1'b1;
            end
            else if (lbp_reg == ls_reg)
            begin
                // no usable break: split before this glyph
                r0        = mk_res(ls_reg, p_m1, 1'b1, 1'b0, stop_reg, ovf_reg);
                n_res     = 2'd1;
                ls_next   = p;
                lbp_next  = p;
                if (fitg)
                begin
                    used_next = LINE_W'(g);
                    tail_next = LINE_W'(g);
                    np_next   = np_p1;
                end
                else
                begin
                    used_next = '0;
                    tail_next = '0;
                    stop_next = 1'b1;
                end
            end
            else
            begin
                // end at the last break and refit the carried word
                r0       = mk_res(ls_reg, lbp_reg, 1'b1, 1'b0, stop_reg, ovf_reg);
                n_res    = 2'd1;
                ls_next  = ls2;
                lbp_next = ls2;
                if (fit2)
                begin
                    used_next = sum2[LINE_W-1:0];
                    if (brk && (p != ls2))
                    begin
                        lbp_next  = p;
                        tail_next = '0;
                    end
                    else
                    begin
                        tail_next = sum2[LINE_W-1:0];
                    end
                    np_next = np_p1;
                end
                else if (p == ls2)
                begin
                    used_next = tail_reg;
                    stop_next = 1'b1;
                end
                else
                begin
                    r1      = mk_res(ls2, p_m1, 1'b1, 1'b0, stop_reg, ovf_reg);
                    n_res   = 2'd2;
                    ls_next  = p;
                    lbp_next = p;
                    if (fitg)
                    begin
                        used_next = LINE_W'(g);
                        tail_next = LINE_W'(g);
                        np_next   = np_p1;
                    end
                    else
                    begin
                        used_next = '0;
                        tail_next = '0;
                        stop_next = 1'b1;
                    end
                end
            end
        end
        if (n_res == 2'd1)
        begin
            r0.last_of_run = 1'b1;
        end
        else if (n_res == 2'd2)
        begin
            r1.last_of_run = 1'b1;
        end
    end

    assign out_valid  = (ocount_reg != '0);
    assign out_pop    = out_valid && out_ready;
    assign owr_ptr_p1 = owr_ptr_reg + OQ_PTR_W'(1);

    always_comb
    begin
        owr_ptr_next = owr_ptr_reg + OQ_PTR_W'(n_res);
        ord_ptr_next = ord_ptr_reg;
        if (out_pop)
        begin
            ord_ptr_next = ord_ptr_reg + OQ_PTR_W'(1);
        end
        ocount_next = ocount_reg + OQ_CNT_W'(n_res) - OQ_CNT_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg      <= LINE_WIDTH_RST;
            np_reg      <= '0;
            ls_reg      <= '0;
            used_reg    <= '0;
            lbp_reg     <= '0;
            tail_reg    <= '0;
            stop_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lw_reg <= cfg_wr_data;
            end
            np_reg      <= np_next;
            ls_reg      <= ls_next;
            used_reg    <= used_next;
            lbp_reg     <= lbp_next;
            tail_reg    <= tail_next;
            stop_reg    <= stop_next;
            ovf_reg     <= ovf_next;
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocount_reg  <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            o_mem[owr_ptr_reg] <= r0;
        end
        if (n_res == 2'd2)
        begin
            o_mem[owr_ptr_p1] <= r1;
        end
    end

    assign head_res      = o_mem[ord_ptr_reg];
    assign line_first    = head_res.first;
    assign line_last     = head_res.last;
    assign line_valid    = head_res.line_valid;
    assign text_done     = head_res.text_done;
    assign text_stopped  = head_res.text_stopped;
    assign text_too_long = head_res.text_too_long;
    assign last_of_run   = head_res.last_of_run;

endmodule

FILE: dv/line_wrap_checker.sv
// Line wrap checker: watches the request and result channels of the line breaker,
// predicts every wrapped line and the end marker, and compares them in order.
// Depends on gww_pkg for widths, the reset line width and the result type.
`timescale 1ns / 1ps

module line_wrap_checker
    import gww_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LINE_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [CODE_W-1:0]  glyph_code,
    input  logic [GLYPH_W-1:0] glyph_width,
    input  logic               end_of_text,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [POS_W-1:0]   line_first,
    input  logic [POS_W-1:0]   line_last,
    input  logic               line_valid,
    input  logic               text_done,
    input  logic               text_stopped,
    input  logic               text_too_long,
    input  logic               last_of_run,
    output int                 mismatches,
    output int                 outstanding,
    output int                 compared
);

    logic [LINE_W-1:0] width_reg;
    logic [NPOS_W-1:0] pos_next;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  brk_pos;
    logic [LINE_W-1:0] used_px;
    logic [LINE_W-1:0] tail_px;
    logic              stopped;
    logic              overflow;

    result_t lines_due[$];
    result_t staged[2];
    int      n_staged;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        compared    = 0;
    end

    function automatic logic breaks_at(input logic [CODE_W-1:0] c);
        return (c < 8'd48) || (c > 8'd57 && c < 8'd64) ||
               (c > 8'd90 && c < 8'd97) || (c > 8'd122 && c < 8'd127);
    endfunction

    task automatic clear_text();
        pos_next  = '0;
        start_pos = '0;
        used_px   = '0;
        brk_pos   = '0;
        tail_px   = '0;
        stopped   = 1'b0;
        overflow  = 1'b0;
    endtask

    task automatic stage_line(input logic [POS_W-1:0] first, input logic [POS_W-1:0] last,
                              input logic valid, input logic done);
        if (n_staged < 2)
        begin
            staged[n_staged].first         = first;
            staged[n_staged].last          = last;
            staged[n_staged].line_valid    = valid;
            staged[n_staged].text_done     = done;
            staged[n_staged].text_stopped  = stopped;
            staged[n_staged].text_too_long = overflow;
            staged[n_staged].last_of_run   = 1'b0;
            n_staged++;
        end
    endtask

    task automatic fit_glyph(input logic [POS_W-1:0] p, input logic [GLYPH_W-1:0] g,
                             input logic brk);
        int   round;
        logic settled;
        settled = 1'b0;
        for (round = 0; round < 4 && !settled; round++)
        begin
            if (int'(used_px) + int'(g) <= int'(width_reg))
            begin
                used_px = used_px + g;
                if (brk && p != start_pos)
                begin
                    brk_pos = p;
                    tail_px = '0;
                end
                else
                begin
                    tail_px = tail_px + g;
                end
                pos_next = {1'b0, p} + 13'd1;
                settled  = 1'b1;
            end
            else if (p == start_pos)
            begin
                stopped = 1'b1;
                settled = 1'b1;
            end
            else if (brk_pos == start_pos)
            begin
                stage_line(start_pos, p - 12'd1, 1'b1, 1'b0);
                start_pos = p;
                used_px   = '0;
                brk_pos   = p;
                tail_px   = '0;
            end
            else
            begin
                stage_line(start_pos, brk_pos, 1'b1, 1'b0);
                start_pos = brk_pos + 12'd1;
                used_px   = tail_px;
                brk_pos   = start_pos;
            end
        end
        if (!settled)
            stopped = 1'b1;
    endtask

    task automatic predict_lines(input logic [CODE_W-1:0] code, input logic [GLYPH_W-1:0] g,
                                 input logic eot);
        logic [NPOS_W-1:0] last_pos;
        int                i;
        n_staged = 0;
        if (eot)
        begin
            last_pos = pos_next - 13'd1;
            if (pos_next > {1'b0, start_pos})
                stage_line(start_pos, last_pos[POS_W-1:0], 1'b1, 1'b0);
            stage_line('0, '0, 1'b0, 1'b1);
            clear_text();
        end
        else if (stopped)
        begin
        end
        else if (pos_next >= NPOS_W'(POS_CAPACITY))
        begin
            overflow = 1'b1;
        end
        else
        begin
            fit_glyph(pos_next[POS_W-1:0], g, breaks_at(code));
        end
        if (n_staged > 0)
            staged[n_staged-1].last_of_run = 1'b1;
        for (i = 0; i < n_staged; i++)
            lines_due.push_back(staged[i]);
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_line();
        result_t want;
        if (lines_due.size() == 0)
        begin
            $error("result with nothing expected: first %0d last %0d valid %0d done %0d",
                   line_first, line_last, line_valid, text_done);
            mismatches++;
        end
        else
        begin
            want = lines_due.pop_front();
            cmp_field("line_first", want.first, line_first);
            cmp_field("line_last", want.last, line_last);
            cmp_field("line_valid", want.line_valid, line_valid);
            cmp_field("text_done", want.text_done, text_done);
            cmp_field("text_stopped", want.text_stopped, text_stopped);
            cmp_field("text_too_long", want.text_too_long, text_too_long);
            cmp_field("last_of_run", want.last_of_run, last_of_run);
            compared++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = LINE_WIDTH_RST;
            clear_text();
            lines_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_line();
            if (cfg_wr_en)
                width_reg = cfg_wr_data;
            if (in_valid && in_ready)
                predict_lines(glyph_code, glyph_width, end_of_text);
            outstanding = lines_due.size();
        end
    end

endmodule

FILE: dv/tb.sv
// Testbench top for the greedy word-wrap line breaker: clock, reset, request and
// result traffic with random idling, line width changes, and the verdict.
// Depends on gww_pkg, greedy_word_wrap_line_breaker_core and line_wrap_checker.
`timescale 1ns / 1ps

module tb;
    import gww_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [LINE_W-1:0]  cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CODE_W-1:0]  glyph_code = '0;
    logic [GLYPH_W-1:0] glyph_width = '0;
    logic               end_of_text = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [POS_W-1:0]   line_first;
    logic [POS_W-1:0]   line_last;
    logic               line_valid;
    logic               text_done;
    logic               text_stopped;
    logic               text_too_long;
    logic               last_of_run;

    int mismatches;
    int outstanding;
    int compared;
    int cycles = 0;
    int items_sent = 0;
    int texts_sent = 0;
    int widths_set = 0;
    bit calm = 1'b0;

    always #6 clk = ~clk;

    greedy_word_wrap_line_breaker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .glyph_code   (glyph_code),
        .glyph_width  (glyph_width),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_first   (line_first),
        .line_last    (line_last),
        .line_valid   (line_valid),
        .text_done    (text_done),
        .text_stopped (text_stopped),
        .text_too_long(text_too_long),
        .last_of_run  (last_of_run)
    );

    line_wrap_checker wrap_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .glyph_code   (glyph_code),
        .glyph_width  (glyph_width),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_first   (line_first),
        .line_last    (line_last),
        .line_valid   (line_valid),
        .text_done    (text_done),
        .text_stopped (text_stopped),
        .text_too_long(text_too_long),
        .last_of_run  (last_of_run),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .compared     (compared)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** greedy_word_wrap_line_breaker_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 17);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send(input logic [CODE_W-1:0] code, input logic [GLYPH_W-1:0] w,
                        input logic eot);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        glyph_code  = code;
        glyph_width = w;
        end_of_text = eot;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (eot)
            texts_sent++;
    endtask

    task automatic close_text();
        send(CODE_W'($urandom_range(0, 255)), GLYPH_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold requests until every line is back, then let the pipe settle before the write
    task automatic set_width(input logic [LINE_W-1:0] w);
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = w;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        widths_set++;
    endtask

    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(0, 15))
            8:       return CODE_W'($urandom_range(65, 90));
            9:       return CODE_W'($urandom_range(48, 57));
            10, 11:  return 8'd32;
            12:      return CODE_W'($urandom_range(33, 47));
            13:      return CODE_W'($urandom_range(0, 255));
            14:      return CODE_W'($urandom_range(88, 99));
            15:      return CODE_W'($urandom_range(120, 130));
            default: return CODE_W'($urandom_range(97, 122));
        endcase
    endfunction

    function automatic logic [LINE_W-1:0] pick_width();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return LINE_W'($urandom_range(1, 16));
            6:       return LINE_W'($urandom_range(200, 1200));
            7:       return LINE_W'($urandom_range(0, 4095));
            default: return LINE_W'($urandom_range(17, 200));
        endcase
    endfunction

    task automatic write_text(input int n_glyphs, input logic [LINE_W-1:0] lw);
        int gmax;
        int k;
        gmax = lw / 5;
        if (gmax > 255)
            gmax = 255;
        if (gmax < 1 && lw != 0)
            gmax = 1;
        for (k = 0; k < n_glyphs; k++)
        begin
            if ($urandom_range(0, 16) == 0)
                send(pick_code(), GLYPH_W'($urandom_range(0, 255)), 1'b0);
            else
                send(pick_code(), GLYPH_W'($urandom_range(0, gmax)), 1'b0);
        end
        close_text();
    endtask

    initial
    begin
        int               rand_start;
        int               k;
        logic [LINE_W-1:0] lw;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        close_text();
        send(8'd32, 8'd10, 1'b0);
        send(8'd97, 8'd100, 1'b0);
        send(8'd98, 8'd100, 1'b0);
        send(8'd44, 8'd5, 1'b0);
        send(8'd99, 8'd100, 1'b0);
        send(8'd100, 8'd50, 1'b0);
        close_text();

        set_width(12'd0);
        send(8'd120, 8'd0, 1'b0);
        send(8'd121, 8'd1, 1'b0);
        send(8'd255, 8'd255, 1'b0);
        close_text();

        set_width(12'd4095);
        send(8'd0, 8'd255, 1'b0);
        send(8'd255, 8'd255, 1'b0);
        send(8'd127, 8'd0, 1'b0);
        close_text();

        set_width(12'd20);
        send(8'd97, 8'd8, 1'b0);
        send(8'd97, 8'd8, 1'b0);
        send(8'd97, 8'd8, 1'b0);
        send(8'd32, 8'd4, 1'b0);
        send(8'd98, 8'd21, 1'b0);
        close_text();

        // run past the position capacity with no idling
        set_width(12'd100);
        calm = 1'b1;
        for (k = 0; k < 4100; k++)
            send(pick_code(), GLYPH_W'($urandom_range(0, 8)), 1'b0);
        close_text();
        calm = 1'b0;

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            lw = pick_width();
            set_width(lw);
            repeat ($urandom_range(1, 4))
            begin
                calm = ($urandom_range(0, 3) == 0);
                write_text($urandom_range(0, 40), lw);
            end
            calm = 1'b0;
        end
        set_width(LINE_WIDTH_RST);
        write_text(30, LINE_WIDTH_RST);

        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d requests in %0d texts under %0d line width settings;",
                 items_sent, texts_sent, widths_set);
        $display("compared %0d results, including a text past the position capacity.",
                 compared);
        if (mismatches == 0 && outstanding == 0)
            $display("** greedy_word_wrap_line_breaker_core: PASSED **");
        else
            $display("** greedy_word_wrap_line_breaker_core: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/gww_pkg.sv
src/gww_front.sv
src/gww_back.sv
src/greedy_word_wrap_line_breaker_core.sv
dv/line_wrap_checker.sv
dv/tb.sv
